/* rtl/dtf_pkg.sv */
// Shared types and constants for the decimal text formatter.
// Used by dtf_div10 and decimal_text_formatter_unit; depends on nothing.
`default_nettype none

package dtf_pkg;

  // Field widths of the request and response items.
  localparam int VALUE_W = 31;
  localparam int MIN_W   = 6;
  localparam int CHAR_W  = 8;
  localparam int DIGIT_W = 4;

  // A 31-bit value has at most ten decimal digits.
  localparam int MAX_VALUE_DIGITS = 10;

  // Default cap on the minimum digit count.
  localparam int DEFAULT_MAX_PAD = 32;

  // ASCII '0' and the terminator byte.
  localparam logic [CHAR_W-1:0] ZERO_CHAR = 8'd48;
  localparam logic [CHAR_W-1:0] NUL_CHAR  = 8'd0;

  // Reciprocal of ten scaled by 2^35; exact for any dividend below 2^32.
  localparam int          RECIP_SHIFT = 35;
  localparam logic [31:0] RECIP_10    = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [MIN_W-1:0]   min_digits;
  } dtf_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } dtf_rsp_t;

  // Result of one pass through the divide-by-ten unit.
  typedef struct packed {
    logic [VALUE_W-1:0] quot;
    logic [DIGIT_W-1:0] rem;
  } dtf_div_t;

endpackage

`default_nettype wire

/* rtl/dtf_div10.sv */
// Divide-by-ten unit: quotient and remainder of one value per cycle.
// Depends on dtf_pkg for widths and the reciprocal constant.
`default_nettype none

module dtf_div10 (
  input  wire logic [dtf_pkg::VALUE_W-1:0] dividend,
  output dtf_pkg::dtf_div_t                result
);
  import dtf_pkg::*;

  localparam int PROD_W = VALUE_W + 32;

  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot_x10;
  logic [VALUE_W-1:0] diff;

  // Multiply by the scaled reciprocal and drop the fraction bits.
  assign prod = PROD_W'(dividend) * PROD_W'(RECIP_10);
  assign quot = VALUE_W'(prod >> RECIP_SHIFT);

  // Remainder is what is left after taking back ten times the quotient.
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign diff     = dividend - quot_x10;

  assign result.quot = quot;
  assign result.rem  = diff[DIGIT_W-1:0];

endmodule

`default_nettype wire

/* rtl/decimal_text_formatter_unit.sv */
// Top level of the decimal text formatter: sequencer, digit buffer, output register.
// Depends on dtf_pkg and instantiates dtf_div10.
//
//   channel | handshake            | payload            | per request
//   req     | req_valid/req_ready  | value, min_digits  | one request
//   rsp     | rsp_valid/rsp_ready  | out_char, last     | up to MAX_PAD_DIGITS+1 bytes
//
// A request is loaded in idle, then converted one decimal digit at a time (at most 10)
// through the divide-by-ten unit, then sent one output byte at a time in the emit phase.
// Synchronous active-high reset returns the sequencer to idle with no response held.
// A stalled response holds the sequencer in its emit phase; req_ready is high only idle.
`default_nettype none

module decimal_text_formatter_unit #(
  parameter int MAX_PAD_DIGITS = dtf_pkg::DEFAULT_MAX_PAD
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire dtf_pkg::dtf_req_t req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output dtf_pkg::dtf_rsp_t      rsp
);
  import dtf_pkg::*;

  localparam int CNT_W = $clog2(MAX_PAD_DIGITS + 1);
  localparam int SAT_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;
  localparam int N_W   = $clog2(MAX_VALUE_DIGITS + 1);
  localparam int IDX_W = $clog2(MAX_VALUE_DIGITS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } state_t;

  state_t             state;
  logic [VALUE_W-1:0] value;
  logic [CNT_W-1:0]   minc;
  logic [N_W-1:0]     n;
  logic [CNT_W-1:0]   pad_left;
  logic [N_W-1:0]     dig_left;
  logic [DIGIT_W-1:0] digits [MAX_VALUE_DIGITS];

  dtf_div_t           div;
  logic [SAT_W-1:0]   min_ext;
  logic [SAT_W-1:0]   min_cap;
  logic [CNT_W-1:0]   n_ext;
  logic [N_W-1:0]     dig_idx;
  logic               rsp_free;

  // Shared divide-by-ten unit works on the remaining value.
  dtf_div10 u_div10 (
    .dividend (value),
    .result   (div)
  );

  // Saturate the requested minimum at the cap.
  assign min_ext = SAT_W'(req.min_digits);
  assign min_cap = SAT_W'(MAX_PAD_DIGITS);

  assign n_ext     = CNT_W'(n);
  assign dig_idx   = dig_left - N_W'(1);
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign req_ready = (state == ST_IDLE);

  // Sequencer, digit buffer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      // Outside the emit phase an accepted byte simply leaves the register.
      if (rsp_valid && rsp_ready && state != ST_EMIT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            value <= req.value;
            minc  <= (min_ext > min_cap) ? CNT_W'(min_cap) : CNT_W'(min_ext);
            n     <= '0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          // One digit per cycle, least significant first.
          if (value == '0 || n == N_W'(MAX_VALUE_DIGITS)) begin
            pad_left <= (minc > n_ext) ? (minc - n_ext) : '0;
            dig_left <= n;
            state    <= ST_EMIT;
          end else begin
            digits[n[IDX_W-1:0]] <= div.rem;
            value                <= div.quot;
            n                    <= n + N_W'(1);
          end
        end
        ST_EMIT: begin
          // Padding zeros, then digits most significant first, then the terminator.
          if (rsp_free) begin
            rsp_valid <= 1'b1;
            if (pad_left != '0) begin
              rsp.out_char <= ZERO_CHAR;
              rsp.last     <= 1'b0;
              pad_left     <= pad_left - CNT_W'(1);
            end else if (dig_left != '0) begin
              rsp.out_char <= ZERO_CHAR + CHAR_W'(digits[dig_idx[IDX_W-1:0]]);
              rsp.last     <= 1'b0;
              dig_left     <= dig_idx;
            end else begin
              rsp.out_char <= NUL_CHAR;
              rsp.last     <= 1'b1;
              state        <= ST_IDLE;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The terminator byte is always a zero character.
  a_last_is_nul: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.last) |-> (rsp.out_char == NUL_CHAR))
    else $error("terminator byte is not zero");

  // Every byte before the terminator is an ASCII digit.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.last) |-> (rsp.out_char >= ZERO_CHAR &&
                                  rsp.out_char <= ZERO_CHAR + CHAR_W'(9)))
    else $error("non-digit character emitted");

  // Ready drops only after a request has been taken.
  a_ready_drop: assert property (@(posedge clk) disable iff (rst)
    $fell(req_ready) |-> $past(req_valid))
    else $error("ready dropped without a request");

  // The digit count never exceeds the largest possible digit count.
  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (dig_left <= N_W'(MAX_VALUE_DIGITS)))
    else $error("digit count out of range");

endmodule

`default_nettype wire

/* tb/decimal_text_formatter_unit_tb.sv */
// Self-checking testbench for decimal_text_formatter_unit: random and directed requests,
// with each response byte checked against a local decimal-text predictor.
// Depends on dtf_pkg and the RTL of decimal_text_formatter_unit; reads no files.
`timescale 1ns / 100ps

module decimal_text_formatter_unit_tb;
  import dtf_pkg::*;

  localparam int MAX_PAD      = DEFAULT_MAX_PAD;
  localparam int RANDOM_REQS  = 435;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 600;
  localparam int HOLD_AFTER   = 120;
  localparam int QUIET_START  = 3000;
  localparam int QUIET_STOP   = 6000;
  localparam int IDLE_PERCENT = 16;
  localparam int DRAIN_CYCLES = 60;

  logic     clk;
  logic     rst;
  logic     req_valid;
  logic     req_ready;
  dtf_req_t req;
  logic     rsp_valid;
  logic     rsp_ready;
  dtf_rsp_t rsp;

  // Requests waiting to be driven and the characters still owed by the block.
  dtf_req_t pending_reqs[$];
  dtf_rsp_t expected_text[$];

  int  total_reqs;
  int  n_reqs_taken;
  int  n_chars_checked;
  int  n_terminators;
  int  n_mismatch;
  int  cycle_count;
  bit  req_taken;
  bit  hold_active;
  bit  hold_done;
  int  hold_count;

  decimal_text_formatter_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  // Clock and the single reset pulse.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_ready = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    n_mismatch++;
  endtask

  // Decides whether a side idles this cycle; never inside the quiet window.
  function automatic bit idle_now();
    if (cycle_count >= QUIET_START && cycle_count < QUIET_STOP) begin
      return 1'b0;
    end
    return $urandom_range(99, 0) < IDLE_PERCENT;
  endfunction

  // Builds the decimal text of one request: zero padding, digits, terminator.
  function automatic void predict_text(input dtf_req_t r);
    logic [3:0]         digit_buf[MAX_VALUE_DIGITS];
    logic [VALUE_W-1:0] rest;
    int                 width;
    int                 n_digits;
    dtf_rsp_t           ch;

    rest     = r.value;
    width    = (r.min_digits > MAX_PAD) ? MAX_PAD : int'(r.min_digits);
    n_digits = 0;
    while (rest != 0 && n_digits < MAX_VALUE_DIGITS) begin
      digit_buf[n_digits] = 4'(rest % 10);
      rest                = rest / 10;
      n_digits++;
    end
    for (int i = 0; i < width - n_digits; i++) begin
      ch.out_char = ZERO_CHAR;
      ch.last     = 1'b0;
      expected_text.push_back(ch);
    end
    for (int i = n_digits - 1; i >= 0; i--) begin
      ch.out_char = ZERO_CHAR + CHAR_W'(digit_buf[i]);
      ch.last     = 1'b0;
      expected_text.push_back(ch);
    end
    ch.out_char = NUL_CHAR;
    ch.last     = 1'b1;
    expected_text.push_back(ch);
  endfunction

  task automatic add_req(input logic [VALUE_W-1:0] v, input logic [MIN_W-1:0] m);
    dtf_req_t r;

    r.value      = v;
    r.min_digits = m;
    pending_reqs.push_back(r);
  endtask

  // Request driver: holds a request until taken, otherwise offers the next one.
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      req_taken = 1'b0;
      if (pending_reqs.size() != 0 && !idle_now()) begin
        req       <= pending_reqs.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, started once enough requests have gone in.
  always @(posedge clk) begin
    if (!rst && !hold_done && n_reqs_taken >= HOLD_AFTER) begin
      hold_active = 1'b1;
      hold_count++;
      if (hold_count >= HOLD_CYCLES) begin
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end
    end
  end

  // Response receiver: random stalls plus the long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= !hold_active && !idle_now();
    end
  end

  // Request monitor: every accepted request feeds the predictor.
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) begin
      predict_text(req);
      req_taken = 1'b1;
      n_reqs_taken++;
    end
  end

  // Response monitor: compares each byte with the oldest expected character.
  always @(posedge clk) begin
    dtf_rsp_t want;

    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_text.size() == 0) begin
        report_mismatch($sformatf("unexpected byte 0x%02h last=%0b", rsp.out_char, rsp.last));
      end else begin
        want = expected_text.pop_front();
        if (rsp.out_char !== want.out_char) begin
          report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
                                    rsp.out_char, want.out_char));
        end
        if (rsp.last !== want.last) begin
          report_mismatch($sformatf("last %0b, expected %0b", rsp.last, want.last));
        end
        n_chars_checked++;
        if (want.last) begin
          n_terminators++;
        end
      end
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters still expected",
               cycle_count, expected_text.size());
      $display("status: fail");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [31:0] raw;
    int          shift;
    logic [5:0]  m;

    // Directed: zero value, extreme values, padding edges, large minimum codes.
    add_req(31'd0, 6'd0);
    add_req(31'd0, 6'd1);
    add_req(31'd0, 6'd32);
    add_req(31'd0, 6'd33);
    add_req(31'd0, 6'd63);
    add_req(31'h7FFF_FFFF, 6'd0);
    add_req(31'h7FFF_FFFF, 6'd10);
    add_req(31'h7FFF_FFFF, 6'd11);
    add_req(31'h7FFF_FFFF, 6'd32);
    add_req(31'h7FFF_FFFF, 6'd63);
    add_req(31'd1, 6'd0);
    add_req(31'd9, 6'd1);
    add_req(31'd10, 6'd1);
    add_req(31'd99, 6'd2);
    add_req(31'd100, 6'd5);
    add_req(31'd1000000000, 6'd0);
    add_req(31'd999999999, 6'd9);
    add_req(31'd123456789, 6'd20);
    add_req(31'h4000_0000, 6'd31);
    add_req(31'h5555_5555, 6'd42);
    add_req(31'h2AAA_AAAA, 6'd21);
    add_req(31'd5, 6'd32);
    add_req(31'd1000000000, 6'd10);
    add_req(31'd7, 6'd34);

    // Random: value widths spread evenly, minimum mostly small, sometimes any code.
    for (int i = 0; i < RANDOM_REQS; i++) begin
      raw   = $urandom & 32'h7FFF_FFFF;
      shift = $urandom_range(31, 0);
      raw   = raw >> (31 - shift);
      if ($urandom_range(7, 0) == 0) begin
        m = 6'($urandom_range(63, 0));
      end else begin
        m = 6'($urandom_range(12, 0));
      end
      add_req(raw[VALUE_W-1:0], m);
    end
    total_reqs = pending_reqs.size();

    while (n_reqs_taken < total_reqs || expected_text.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d requests into %0d checked characters (%0d terminators).",
             n_reqs_taken, n_chars_checked, n_terminators);
    $display("Included padding to the cap, saturated minimum codes and a %0d-cycle stall.",
             HOLD_CYCLES);
    if (n_mismatch == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/dtf_pkg.sv
rtl/dtf_div10.sv
rtl/decimal_text_formatter_unit.sv
tb/decimal_text_formatter_unit_tb.sv
